// ----- rtl/core/assert_macros.svh -----
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/core/pps_pkg.sv -----
`default_nettype none

package pps_pkg;

    // commands from the controller to the datapath
    typedef struct packed {
        logic latch;
        logic load;
        logic scan_rd;
        logic update;
        logic emit;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic scan_last;
    } status_t;

endpackage

`default_nettype wire

// ----- rtl/core/pps_ctrl.sv -----
`default_nettype none

module pps_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic            operation,
    input  wire pps_pkg::status_t status,
    output pps_pkg::cmd_t        cmd,
    output logic                 busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_DRAIN,
        S_UPDATE,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   accept;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.latch  = accept;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = operation ? S_SCAN : S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/pps_datapath.sv -----
`default_nettype none

module pps_datapath #(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire pps_pkg::cmd_t    cmd,
    output pps_pkg::status_t      status,
    input  wire logic [3:0]       task_slot,
    input  wire logic [15:0]      arrival_time,
    input  wire logic [15:0]      burst_length,
    input  wire logic [7:0]       task_priority,
    output logic                  valid,
    output logic [15:0]           tick_time,
    output logic                  ran_task,
    output logic [3:0]            chosen_slot,
    output logic                  task_finished,
    output logic [15:0]           turnaround,
    output logic [15:0]           waiting,
    output logic                  all_done
);

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int TB = TIME_BITS;

    // task table
    logic [TB-1:0] arr_mem   [MAX_TASKS];
    logic [TB-1:0] burst_mem [MAX_TASKS];
    logic [TB-1:0] rem_mem   [MAX_TASKS];
    logic [7:0]    pri_mem   [MAX_TASKS];
    logic [MAX_TASKS-1:0] loaded_reg;

    // latched input word
    logic [3:0]    slot_reg;
    logic [TB-1:0] in_arr_reg;
    logic [TB-1:0] in_burst_reg;
    logic [7:0]    in_pri_reg;

    logic [TB-1:0] time_reg;

    // scan pipeline
    logic [IW-1:0] idx_reg;
    logic          rd_valid_reg;
    logic [IW-1:0] rd_idx_reg;
    logic [TB-1:0] rd_arr_reg;
    logic [TB-1:0] rd_burst_reg;
    logic [TB-1:0] rd_rem_reg;
    logic [7:0]    rd_pri_reg;
    logic          rd_loaded_reg;

    // running best
    logic          found_reg;
    logic          any_reg;
    logic          multi_reg;
    logic [IW-1:0] best_idx_reg;
    logic [TB-1:0] best_arr_reg;
    logic [TB-1:0] best_burst_reg;
    logic [TB-1:0] best_rem_reg;
    logic [7:0]    best_pri_reg;

    // update stage
    logic          fin_reg;
    logic [TB-1:0] tat_reg;

    // outputs
    logic          valid_reg;
    logic [15:0]   tick_time_reg;
    logic          ran_reg;
    logic [3:0]    chosen_reg;
    logic          finished_reg;
    logic [15:0]   tat_out_reg;
    logic [15:0]   wt_out_reg;
    logic          done_reg;

    logic          slot_ok;
    logic [IW-1:0] slot_idx;
    logic          rd_work;
    logic          rd_elig;
    logic          rd_better;
    logic [TB-1:0] rem_dec;
    logic [TB-1:0] time_inc;
    logic [TB-1:0] wt_val;

    assign slot_ok  = (32'(slot_reg) < MAX_TASKS);
    assign slot_idx = IW'(slot_reg);
    assign status.scan_last = (idx_reg == IW'(MAX_TASKS - 1));

    assign rd_work   = rd_loaded_reg && (rd_rem_reg != '0);
    assign rd_elig   = rd_work && (rd_arr_reg <= time_reg);
    assign rd_better = !found_reg
                       || (rd_pri_reg < best_pri_reg)
                       || ((rd_pri_reg == best_pri_reg) && (rd_arr_reg < best_arr_reg));

    assign rem_dec  = best_rem_reg - TB'(1);
    assign time_inc = time_reg + TB'(1);
    assign wt_val   = (tat_reg >= best_burst_reg) ? (tat_reg - best_burst_reg) : '0;

    // input latch
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            slot_reg     <= task_slot;
            in_arr_reg   <= TB'(arrival_time);
            in_burst_reg <= TB'(burst_length);
            in_pri_reg   <= task_priority;
        end
    end

    // table memories, one write address and one read address per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.load && slot_ok)
        begin
            arr_mem[slot_idx]   <= in_arr_reg;
            burst_mem[slot_idx] <= in_burst_reg;
            pri_mem[slot_idx]   <= in_pri_reg;
            rem_mem[slot_idx]   <= in_burst_reg;
        end
        else if (cmd.update && found_reg)
        begin
            rem_mem[best_idx_reg] <= rem_dec;
        end
        if (cmd.scan_rd)
        begin
            rd_idx_reg   <= idx_reg;
            rd_arr_reg   <= arr_mem[idx_reg];
            rd_burst_reg <= burst_mem[idx_reg];
            rd_rem_reg   <= rem_mem[idx_reg];
            rd_pri_reg   <= pri_mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg    <= '0;
            time_reg      <= '0;
            idx_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            rd_loaded_reg <= 1'b0;
            found_reg     <= 1'b0;
            any_reg       <= 1'b0;
            multi_reg     <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.scan_rd;
            valid_reg    <= cmd.emit;
            if (cmd.load && slot_ok)
            begin
                loaded_reg[slot_idx] <= 1'b1;
            end
            if (cmd.latch)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
                any_reg   <= 1'b0;
                multi_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan_rd)
                begin
                    idx_reg       <= idx_reg + IW'(1);
                    rd_loaded_reg <= loaded_reg[idx_reg];
                end
                if (rd_valid_reg)
                begin
                    if (rd_work)
                    begin
                        any_reg <= 1'b1;
                        if (any_reg)
                        begin
                            multi_reg <= 1'b1;
                        end
                    end
                    if (rd_elig && rd_better)
                    begin
                        found_reg <= 1'b1;
                    end
                end
            end
            if (cmd.update)
            begin
                time_reg <= time_inc;
            end
        end
    end

    // best candidate and result registers
    always_ff @(posedge clk)
    begin
        if (rd_valid_reg && rd_elig && rd_better)
        begin
            best_idx_reg   <= rd_idx_reg;
            best_arr_reg   <= rd_arr_reg;
            best_burst_reg <= rd_burst_reg;
            best_rem_reg   <= rd_rem_reg;
            best_pri_reg   <= rd_pri_reg;
        end
        if (cmd.update)
        begin
            tick_time_reg <= 16'(time_reg);
            fin_reg       <= found_reg && (rem_dec == '0);
            tat_reg       <= time_inc - best_arr_reg;
        end
        if (cmd.emit)
        begin
            ran_reg      <= found_reg;
            chosen_reg   <= found_reg ? 4'(best_idx_reg) : 4'd0;
            finished_reg <= fin_reg;
            tat_out_reg  <= fin_reg ? 16'(tat_reg) : 16'd0;
            wt_out_reg   <= fin_reg ? 16'(wt_val) : 16'd0;
            // only the chosen task can be left with work when it finishes
            done_reg     <= !any_reg || (!multi_reg && fin_reg);
        end
    end

    assign valid         = valid_reg;
    assign tick_time     = tick_time_reg;
    assign ran_task      = ran_reg;
    assign chosen_slot   = chosen_reg;
    assign task_finished = finished_reg;
    assign turnaround    = tat_out_reg;
    assign waiting       = wt_out_reg;
    assign all_done      = done_reg;

endmodule

`default_nettype wire

// ----- rtl/core/preemptive_priority_scheduler_unit.sv -----
// channel  | handshake            | word
// ---------+----------------------+------------------------------------------------
// input    | start & !busy        | operation, task_slot, arrival_time,
//          |                      | burst_length, task_priority
// result   | valid (one cycle)    | tick_time, ran_task, chosen_slot, task_finished,
//          |                      | turnaround, waiting, all_done
//
// a load word keeps busy high for 1 cycle; a tick word keeps it high through the scan, drain,
// update and finish states, with one table read per cycle during the scan
// the tick result shows on valid in the same cycle that busy drops, when a new word
// may already be taken
// rst_n clears the loaded flags and the time counter; table contents are not cleared
// the receiver cannot stall: each result is marked by valid for exactly one cycle
`default_nettype none

module preemptive_priority_scheduler_unit #(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        operation,
    input  wire logic [3:0]  task_slot,
    input  wire logic [15:0] arrival_time,
    input  wire logic [15:0] burst_length,
    input  wire logic [7:0]  task_priority,
    output logic             valid,
    output logic [15:0]      tick_time,
    output logic             ran_task,
    output logic [3:0]       chosen_slot,
    output logic             task_finished,
    output logic [15:0]      turnaround,
    output logic [15:0]      waiting,
    output logic             all_done
);

    pps_pkg::cmd_t    cmd;
    pps_pkg::status_t status;

    pps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    pps_datapath #(
        .MAX_TASKS (MAX_TASKS),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .task_slot     (task_slot),
        .arrival_time  (arrival_time),
        .burst_length  (burst_length),
        .task_priority (task_priority),
        .valid         (valid),
        .tick_time     (tick_time),
        .ran_task      (ran_task),
        .chosen_slot   (chosen_slot),
        .task_finished (task_finished),
        .turnaround    (turnaround),
        .waiting       (waiting),
        .all_done      (all_done)
    );

endmodule

`default_nettype wire

// ----- rtl/core/pps_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module pps_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        valid,
    input wire logic        ran_task,
    input wire logic [3:0]  chosen_slot,
    input wire logic        task_finished,
    input wire logic [15:0] turnaround,
    input wire logic [15:0] waiting
);

    // an accepted word always raises busy in the cycle after it is taken
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)

    // a result only appears once the tick work is over
    `ASSERT_IMPL(a_valid_idle, clk, rst_n, valid, !busy)

    // results never come back to back
    `ASSERT_NEXT(a_valid_single, clk, rst_n, valid, !valid)

    // idle tick reports nothing else
    `ASSERT_IMPL(a_idle_clean, clk, rst_n, valid && !ran_task,
        chosen_slot == 4'd0 && !task_finished && turnaround == 16'd0 && waiting == 16'd0)

    // a finish needs a task that ran
    `ASSERT_IMPL(a_finish_ran, clk, rst_n, valid && task_finished, ran_task)

endmodule

bind preemptive_priority_scheduler_unit pps_checker u_pps_checker (.*);

`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none

module tb_top;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;
    localparam int NUM_SLOTS = 16;
    localparam int QUIET_LIMIT = 4000;
    localparam int PRINT_LIMIT = 40;

    typedef struct {
        logic [15:0] tick_time;
        logic        ran_task;
        logic [3:0]  chosen_slot;
        logic        task_finished;
        logic [15:0] turnaround;
        logic [15:0] waiting;
        logic        all_done;
    } sched_tick_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        operation = 1'b0;
    logic [3:0]  task_slot = '0;
    logic [15:0] arrival_time = '0;
    logic [15:0] burst_length = '0;
    logic [7:0]  task_priority = '0;
    logic        busy;
    logic        valid;
    logic [15:0] tick_time;
    logic        ran_task;
    logic [3:0]  chosen_slot;
    logic        task_finished;
    logic [15:0] turnaround;
    logic [15:0] waiting;
    logic        all_done;

    // scheduler state as the testbench sees it
    logic [15:0] task_arrival [NUM_SLOTS];
    logic [15:0] task_burst [NUM_SLOTS];
    logic [15:0] task_left [NUM_SLOTS];
    logic [7:0]  task_prio [NUM_SLOTS];
    bit          task_loaded [NUM_SLOTS];
    logic [15:0] sched_time = '0;

    sched_tick_t expected_ticks [$];
    int          mismatch_count = 0;
    int          words_sent = 0;
    int          sender_idle_pct = 0;
    int          quiet_cycles = 0;

    preemptive_priority_scheduler_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .task_slot     (task_slot),
        .arrival_time  (arrival_time),
        .burst_length  (burst_length),
        .task_priority (task_priority),
        .valid         (valid),
        .tick_time     (tick_time),
        .ran_task      (ran_task),
        .chosen_slot   (chosen_slot),
        .task_finished (task_finished),
        .turnaround    (turnaround),
        .waiting       (waiting),
        .all_done      (all_done)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic bit work_pending();
        bit pending;
        pending = 1'b0;
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            if (task_loaded[k] && task_left[k] != 16'd0)
                pending = 1'b1;
        end
        return pending;
    endfunction

    // one time unit: pick the ready task, run it, advance the clock
    function automatic sched_tick_t predict_tick();
        sched_tick_t res;
        bit          found;
        int          best;
        logic [15:0] next_time;
        found = 1'b0;
        best = 0;
        res.tick_time = sched_time;
        res.task_finished = 1'b0;
        res.turnaround = '0;
        res.waiting = '0;
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            if (!task_loaded[k] || task_left[k] == 16'd0 || task_arrival[k] > sched_time)
                continue;
            if (!found || task_prio[k] < task_prio[best]
                || (task_prio[k] == task_prio[best] && task_arrival[k] < task_arrival[best]))
            begin
                best = k;
                found = 1'b1;
            end
        end
        next_time = sched_time + 16'd1;
        sched_time = next_time;
        if (found)
        begin
            task_left[best] = task_left[best] - 16'd1;
            if (task_left[best] == 16'd0)
            begin
                res.task_finished = 1'b1;
                res.turnaround = next_time - task_arrival[best];
                // a burst that spans the time wrap gives a short turnaround
                res.waiting = (res.turnaround >= task_burst[best])
                            ? res.turnaround - task_burst[best] : 16'd0;
            end
        end
        res.ran_task = found;
        res.chosen_slot = found ? 4'(best) : 4'd0;
        res.all_done = !work_pending();
        return res;
    endfunction

    task automatic send_word(input logic op, input logic [3:0] slot, input logic [15:0] arr,
                             input logic [15:0] bst, input logic [7:0] pri);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        operation = op;
        task_slot = slot;
        arrival_time = arr;
        burst_length = bst;
        task_priority = pri;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        words_sent++;
        if (op == OP_LOAD)
        begin
            task_arrival[slot] = arr;
            task_burst[slot] = bst;
            task_left[slot] = bst;
            task_prio[slot] = pri;
            task_loaded[slot] = 1'b1;
        end
        else
        begin
            expected_ticks.push_back(predict_tick());
        end
    endtask

    // tick word with junk in the fields the block ignores
    task automatic tick_word();
        send_word(OP_TICK, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
    endtask

    // short task that becomes ready soon; small priorities make ties common
    task automatic load_short_task();
        logic [7:0] pri;
        pri = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                          : 8'($urandom_range(0, 255));
        send_word(OP_LOAD, 4'($urandom_range(0, 15)), sched_time + 16'($urandom_range(0, 6)),
                  16'($urandom_range(1, 5)), pri);
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want, input logic [15:0] at_time);
        if (got !== want)
            report_mismatch($sformatf("tick %0d %s got %0h expected %0h",
                                      at_time, name, got, want));
    endtask

    always @(posedge clk)
    begin
        sched_tick_t want;
        if (rst_n && valid === 1'b1)
        begin
            if (expected_ticks.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word, tick_time %0h", tick_time));
            end
            else
            begin
                want = expected_ticks.pop_front();
                check_field("tick_time", tick_time, want.tick_time, want.tick_time);
                check_field("ran_task", 16'(ran_task), 16'(want.ran_task), want.tick_time);
                check_field("chosen_slot", 16'(chosen_slot), 16'(want.chosen_slot),
                            want.tick_time);
                check_field("task_finished", 16'(task_finished), 16'(want.task_finished),
                            want.tick_time);
                check_field("turnaround", turnaround, want.turnaround, want.tick_time);
                check_field("waiting", waiting, want.waiting, want.tick_time);
                check_field("all_done", 16'(all_done), 16'(want.all_done), want.tick_time);
            end
        end
    end

    // ends the run if nothing moves in either direction for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || valid === 1'b1)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic test_directed();
        sender_idle_pct = 0;
        tick_word();                                           // empty table: idle tick
        send_word(OP_LOAD, 4'd0, 16'd0, 16'd0, 8'd0);          // zero burst never runs
        tick_word();
        send_word(OP_LOAD, 4'd15, 16'hFFFF, 16'hFFFF, 8'hFF);  // far in the future
        send_word(OP_LOAD, 4'd3, 16'd1, 16'd2, 8'd5);
        send_word(OP_LOAD, 4'd4, 16'd1, 16'd1, 8'd5);          // same priority and arrival
        send_word(OP_LOAD, 4'd2, 16'd2, 16'd1, 8'd5);          // lower slot, later arrival
        send_word(OP_LOAD, 4'd9, 16'd4, 16'd1, 8'd0);          // preempts when it arrives
        repeat (3) tick_word();
        send_word(OP_LOAD, 4'd3, 16'd0, 16'd3, 8'd5);          // reload restarts the work
        repeat (8) tick_word();
        send_word(OP_LOAD, 4'd15, 16'd0, 16'd0, 8'd0);
        tick_word();
    endtask

    task automatic test_random_workloads(input int n_words, input int idle_pct);
        int stop_at;
        int guard;
        logic [15:0] ahead;
        sender_idle_pct = idle_pct;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                send_word(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                          16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                          8'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 2)) tick_word();
            end
            else
            begin
                // retire leftovers that would block or outlive the next batch
                for (int k = 0; k < NUM_SLOTS; k++)
                begin
                    ahead = task_arrival[k] - sched_time;
                    if (task_loaded[k] && task_left[k] != 16'd0
                        && (task_left[k] > 16'd64
                            || (task_arrival[k] > sched_time && ahead > 16'd16)))
                        send_word(OP_LOAD, 4'(k), 16'($urandom_range(0, 65535)), 16'd0,
                                  8'($urandom_range(0, 255)));
                end
                repeat ($urandom_range(1, 6)) load_short_task();
                guard = 0;
                while (work_pending() && guard < 40)
                begin
                    if ($urandom_range(0, 9) == 0)
                        load_short_task();
                    tick_word();
                    guard++;
                end
                repeat ($urandom_range(0, 2)) tick_word();
            end
        end
    endtask

    initial
    begin
        foreach (task_loaded[k])
        begin
            task_loaded[k] = 1'b0;
            task_arrival[k] = '0;
            task_burst[k] = '0;
            task_left[k] = '0;
            task_prio[k] = '0;
        end
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random_workloads(230, 0);
        test_random_workloads(230, 49);
        test_random_workloads(230, 13);
        @(negedge clk);
        start = 1'b0;
        while (expected_ticks.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
